/* src/tspp_pkg.sv */
package tspp_pkg;

    localparam int PmtEntries  = 16;
    localparam int PmtIdxW     = $clog2(PmtEntries);
    localparam int PacketBytes = 188;
    localparam logic [7:0] SyncValue = 8'h47;

    localparam logic [1:0] KindHeader  = 2'd0;
    localparam logic [1:0] KindPcr     = 2'd1;
    localparam logic [1:0] KindPayload = 2'd2;
    localparam logic [1:0] KindSyncErr = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [12:0] pid;
        logic        unit_start;
        logic        transport_error;
        logic [1:0]  scrambling;
        logic [1:0]  field_control;
        logic [3:0]  continuity;
        logic [32:0] clock_base;
        logic [8:0]  clock_extension;
        logic [7:0]  payload_byte;
        logic [31:0] packet_index;
    } t_result;

endpackage

/* src/ts_packet_parser_top.sv */
// Channel | Direction | Handshake            | Payload
// input   | in        | i_valid / o_ready    | i_stream_byte
// result  | out       | o_valid / i_ready    | o_kind .. o_packet_index
// config  | in        | i_cfg_we             | i_cfg_data (report_pcr)
// One stream byte per cycle while the output buffer has room: each byte updates
// the parse state in the cycle it is accepted and its result, if any, is registered
// into a two-entry output buffer. Reset clears all control state and
// the PMT table valid bits. When the output buffer holds two results the input
// stalls until one is taken.
module ts_packet_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [12:0] o_pid,
    output logic        o_unit_start,
    output logic        o_transport_error,
    output logic [1:0]  o_scrambling,
    output logic [1:0]  o_field_control,
    output logic [3:0]  o_continuity,
    output logic [32:0] o_clock_base,
    output logic [8:0]  o_clock_extension,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_packet_index
);

    logic        r_report_pcr;
    logic [7:0]  r_pos,   n_pos;
    logic [23:0] r_hdr,   n_hdr;
    logic [7:0]  r_alen,  n_alen;
    logic [7:0]  r_aflg,  n_aflg;
    logic [47:0] r_clk,   n_clk;
    logic [11:0] r_left,  n_left;
    logic [31:0] r_eshf,  n_eshf;
    logic [7:0]  r_eidx,  n_eidx;
    logic [31:0] r_pcnt,  n_pcnt;

    tspp_pkg::t_result r_buf [2];
    logic [1:0]        r_cnt;
    logic              r_rd;
    tspp_pkg::t_result w_res;
    logic              w_emit;
    logic              w_acc, w_pop;
    logic              w_pmt_wr, w_pmt_hit;

    assign o_ready = (r_cnt != 2'd2);
    assign w_acc   = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_ready;

    tspp_pmt_match u_pmt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_pmt_wr),
        .i_wr_idx (r_eidx[tspp_pkg::PmtIdxW-1:0]),
        .i_wr_pid (n_eshf[12:0]),
        .i_pid    (r_hdr[20:8]),
        .o_hit    (w_pmt_hit)
    );

    // parse one byte
    always_comb begin
        logic [1:0]  afc;
        logic [8:0]  pstart;
        logic [8:0]  off;
        logic [11:0] len;
        logic [11:0] dec;
        afc = r_hdr[5:4];
        n_pos = r_pos; n_hdr = r_hdr; n_alen = r_alen; n_aflg = r_aflg;
        n_clk = r_clk; n_left = r_left; n_eshf = r_eshf; n_eidx = r_eidx;
        n_pcnt = r_pcnt;
        w_emit = 1'b0;
        w_pmt_wr = 1'b0;
        w_res = '0;
        w_res.packet_index = r_pcnt;
        pstart = afc[1] ? (9'd5 + {1'b0, r_alen}) : 9'd4;
        off = {1'b0, r_pos} - pstart;
        len = '0;
        dec = r_left - 12'd1;
        if (r_pos == 8'd0 || r_pos >= 8'(tspp_pkg::PacketBytes)) begin
            if (i_stream_byte == tspp_pkg::SyncValue) begin
                n_pcnt = r_pcnt + 32'd1;
                n_hdr = '0; n_alen = '0; n_aflg = '0; n_left = '0;
                n_eshf = '0; n_eidx = '0; n_pos = 8'd1;
            end else if (r_pos != 8'd0) begin
                n_pos = 8'd0;
                w_emit = 1'b1;
                w_res.kind = tspp_pkg::KindSyncErr;
                w_res.payload_byte = i_stream_byte;
            end
        end else if (r_pos <= 8'd3) begin
            n_hdr = {r_hdr[15:0], i_stream_byte};
            n_pos = r_pos + 8'd1;
            if (r_pos == 8'd3) begin
                w_emit = 1'b1;
                w_res.kind = tspp_pkg::KindHeader;
                w_res.pid = n_hdr[20:8];
                w_res.unit_start = n_hdr[22];
                w_res.transport_error = n_hdr[23];
                w_res.scrambling = n_hdr[7:6];
                w_res.field_control = n_hdr[5:4];
                w_res.continuity = n_hdr[3:0];
            end
        end else begin
            n_pos = r_pos + 8'd1;
            w_res.pid = r_hdr[20:8];
            w_res.unit_start = r_hdr[22];
            w_res.transport_error = r_hdr[23];
            w_res.scrambling = r_hdr[7:6];
            w_res.field_control = r_hdr[5:4];
            w_res.continuity = r_hdr[3:0];
            // adaptation field
            if (afc[1]) begin
                if (r_pos == 8'd4) begin
                    n_alen = i_stream_byte;
                end else if ({1'b0, r_pos} <= 9'd4 + {1'b0, r_alen}) begin
                    if (r_pos == 8'd5) begin
                        n_aflg = i_stream_byte;
                    end else if (r_aflg[4] && r_pos <= 8'd11) begin
                        n_clk = {r_clk[39:0], i_stream_byte};
                        if (r_pos == 8'd11 && r_report_pcr) begin
                            w_emit = 1'b1;
                            w_res.kind = tspp_pkg::KindPcr;
                            w_res.clock_base = n_clk[47:15];
                            w_res.clock_extension = n_clk[8:0];
                        end
                    end
                end
            end
            // payload
            if (afc[0] && {1'b0, r_pos} >= pstart) begin
                if (r_hdr[20:8] == 13'd0) begin
                    if (off == 9'd2) begin
                        n_eshf = {24'd0, i_stream_byte};
                    end else if (off == 9'd3) begin
                        len = {r_eshf[3:0], i_stream_byte};
                        n_left = (len >= 12'd9) ? {len - 12'd9} & 12'hFFC : 12'd0;
                    end else if (off >= 9'd9 && r_left != 12'd0) begin
                        n_eshf = {r_eshf[23:0], i_stream_byte};
                        n_left = dec;
                        if (dec[1:0] == 2'b00) begin
                            w_pmt_wr = (n_eshf[31:16] != 16'd0) &&
                                (r_eidx < 8'(tspp_pkg::PmtEntries));
                            if (r_eidx != 8'd255) begin
                                n_eidx = r_eidx + 8'd1;
                            end
                        end
                    end
                end else if (!w_pmt_hit) begin
                    w_emit = 1'b1;
                    w_res.kind = tspp_pkg::KindPayload;
                    w_res.payload_byte = i_stream_byte;
                end
            end
        end
        if (!w_acc) begin
            w_pmt_wr = 1'b0;
        end
    end

    // advance parse state and output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_pcr <= 1'b0;
            r_pos <= '0; r_hdr <= '0; r_alen <= '0; r_aflg <= '0;
            r_clk <= '0; r_left <= '0; r_eshf <= '0; r_eidx <= '0;
            r_pcnt <= '0; r_cnt <= '0; r_rd <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_report_pcr <= i_cfg_data;
            end
            if (w_acc) begin
                r_pos <= n_pos; r_hdr <= n_hdr; r_alen <= n_alen; r_aflg <= n_aflg;
                r_clk <= n_clk; r_left <= n_left; r_eshf <= n_eshf;
                r_eidx <= n_eidx; r_pcnt <= n_pcnt;
            end
            r_cnt <= r_cnt + {1'b0, w_acc && w_emit} - {1'b0, w_pop};
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // write results into the buffer slot after the occupied ones
    always_ff @(posedge i_clk) begin
        if (w_acc && w_emit) begin
            r_buf[r_rd ^ (r_cnt != 2'd0)] <= w_res;
        end
    end

    assign o_kind            = r_buf[r_rd].kind;
    assign o_pid             = r_buf[r_rd].pid;
    assign o_unit_start      = r_buf[r_rd].unit_start;
    assign o_transport_error = r_buf[r_rd].transport_error;
    assign o_scrambling      = r_buf[r_rd].scrambling;
    assign o_field_control   = r_buf[r_rd].field_control;
    assign o_continuity      = r_buf[r_rd].continuity;
    assign o_clock_base      = r_buf[r_rd].clock_base;
    assign o_clock_extension = r_buf[r_rd].clock_extension;
    assign o_payload_byte    = r_buf[r_rd].payload_byte;
    assign o_packet_index    = r_buf[r_rd].packet_index;

    // buffer never overflows
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("result buffer overflow");
    // a sync error always leaves the block hunting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_emit && w_res.kind == tspp_pkg::KindSyncErr) |=> r_pos == 8'd0)
        else $error("no hunt after sync error");
    // position stays within a packet
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 8'(tspp_pkg::PacketBytes))
        else $error("byte position out of range");

endmodule

/* src/tspp_pmt_match.sv */
module tspp_pmt_match (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [tspp_pkg::PmtIdxW-1:0]      i_wr_idx,
    input  logic [12:0]                       i_wr_pid,
    input  logic [12:0]                       i_pid,
    output logic                              o_hit
);

    logic [12:0]                     r_table [tspp_pkg::PmtEntries];
    logic [tspp_pkg::PmtEntries-1:0] r_valid;
    logic [tspp_pkg::PmtEntries-1:0] w_hits;

    // store PMT PIDs, mark entries valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr) begin
            r_valid[i_wr_idx] <= 1'b1;
        end
        if (i_wr) begin
            r_table[i_wr_idx] <= i_wr_pid;
        end
    end

    // compare all entries in parallel
    always_comb begin
        for (int i = 0; i < tspp_pkg::PmtEntries; i++) begin
            w_hits[i] = r_valid[i] && (r_table[i] == i_pid);
        end
    end

    assign o_hit = |w_hits;

endmodule

/* test/tb_ts_packet_parser_top.sv */
`timescale 1ns / 1ps

module tb_ts_packet_parser_top;

    localparam int WatchdogLimit = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_stream_byte;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [12:0] o_pid;
    logic        o_unit_start;
    logic        o_transport_error;
    logic [1:0]  o_scrambling;
    logic [1:0]  o_field_control;
    logic [3:0]  o_continuity;
    logic [32:0] o_clock_base;
    logic [8:0]  o_clock_extension;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_packet_index;

    ts_packet_parser_top DUT (.*);

    // parser state mirror
    logic        pcr_enable;
    int unsigned pos_q;
    logic [23:0] hdr_q;
    logic [7:0]  af_len_q;
    logic [7:0]  af_flags_q;
    logic [47:0] pcr_shift_q;
    int unsigned sec_left_q;
    logic [31:0] entry_q;
    int unsigned entry_idx_q;
    logic [12:0] pmt_pid_q [tspp_pkg::PmtEntries];
    logic [tspp_pkg::PmtEntries-1:0] pmt_valid_q;
    logic [31:0] pkt_count_q;

    tspp_pkg::t_result expected_results [$];
    int          mismatch_count = 0;
    logic        hold_off_rx = 1'b0;
    int unsigned idle_cycles = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic tspp_pkg::t_result make_result(logic [1:0] kind, logic use_hdr,
                                                      logic [32:0] base, logic [8:0] ext,
                                                      logic [7:0] pbyte);
        tspp_pkg::t_result r;
        logic [23:0] h;
        h = use_hdr ? hdr_q : 24'd0;
        r.kind            = kind;
        r.pid             = h[20:8];
        r.unit_start      = h[22];
        r.transport_error = h[23];
        r.scrambling      = h[7:6];
        r.field_control   = h[5:4];
        r.continuity      = h[3:0];
        r.clock_base      = base;
        r.clock_extension = ext;
        r.payload_byte    = pbyte;
        r.packet_index    = pkt_count_q;
        return r;
    endfunction

    function automatic logic pid_is_pmt(logic [12:0] pid);
        for (int i = 0; i < tspp_pkg::PmtEntries; i++) begin
            if (pmt_valid_q[i] && pmt_pid_q[i] == pid) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void parse_pat_byte(int unsigned off, logic [7:0] b);
        int unsigned len;
        if (off == 2) begin
            entry_q = {24'd0, b};
        end else if (off == 3) begin
            len = {20'd0, entry_q[3:0], b};
            sec_left_q = (len >= 9) ? ((len - 9) / 4) * 4 : 0;
        end else if (off >= 9 && sec_left_q > 0) begin
            entry_q = {entry_q[23:0], b};
            sec_left_q--;
            if (sec_left_q % 4 == 0) begin
                if (entry_q[31:16] != 16'd0 && entry_idx_q < tspp_pkg::PmtEntries) begin
                    pmt_pid_q[entry_idx_q]   = entry_q[12:0];
                    pmt_valid_q[entry_idx_q] = 1'b1;
                end
                if (entry_idx_q < 255) entry_idx_q++;
            end
        end
    endfunction

    // advance the mirror by one accepted byte, queue any result
    function automatic void predict_byte(logic [7:0] b);
        int unsigned pos;
        int unsigned pstart;
        logic [1:0]  afc;
        pos = pos_q;
        if (pos == 0 || pos >= tspp_pkg::PacketBytes) begin
            if (b == tspp_pkg::SyncValue) begin
                pkt_count_q++;
                hdr_q = '0; af_len_q = '0; af_flags_q = '0;
                sec_left_q = 0; entry_q = '0; entry_idx_q = 0;
                pos_q = 1;
            end else if (pos >= tspp_pkg::PacketBytes) begin
                pos_q = 0;
                expected_results.push_back(
                    make_result(tspp_pkg::KindSyncErr, 1'b0, '0, '0, b));
            end
            return;
        end
        if (pos <= 3) begin
            hdr_q = {hdr_q[15:0], b};
            pos_q = pos + 1;
            if (pos == 3)
                expected_results.push_back(
                    make_result(tspp_pkg::KindHeader, 1'b1, '0, '0, '0));
            return;
        end
        afc = hdr_q[5:4];
        if (afc[1]) begin
            if (pos == 4) begin
                af_len_q = b;
            end else if (pos <= 4 + af_len_q) begin
                if (pos == 5) begin
                    af_flags_q = b;
                end else if (af_flags_q[4] && pos <= 11) begin
                    pcr_shift_q = {pcr_shift_q[39:0], b};
                    if (pos == 11 && pcr_enable)
                        expected_results.push_back(make_result(tspp_pkg::KindPcr, 1'b1,
                            pcr_shift_q[47:15], pcr_shift_q[8:0], '0));
                end
            end
        end
        pstart = afc[1] ? 5 + af_len_q : 4;
        if (afc[0] && pos >= pstart) begin
            if (hdr_q[20:8] == 13'd0)
                parse_pat_byte(pos - pstart, b);
            else if (!pid_is_pmt(hdr_q[20:8]))
                expected_results.push_back(
                    make_result(tspp_pkg::KindPayload, 1'b1, '0, '0, b));
        end
        pos_q = pos + 1;
    endfunction

    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one byte and wait until it is accepted; valid stays up for the next byte
    task automatic send_byte(logic [7:0] b, logic with_gaps = 1'b1);
        int unsigned gap;
        gap = with_gaps ? random_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_byte(b);
        @(negedge i_clk);
    endtask

    // drop valid at the end of a burst
    task automatic stop_input();
        i_valid <= 1'b0;
    endtask

    task automatic send_packet(logic [7:0] bytes [tspp_pkg::PacketBytes],
                               logic with_gaps = 1'b1);
        for (int i = 0; i < tspp_pkg::PacketBytes; i++) send_byte(bytes[i], with_gaps);
    endtask

    function automatic void build_packet(output logic [7:0] p [tspp_pkg::PacketBytes],
                                         input logic [12:0] pid, input logic [1:0] afc,
                                         input int unsigned af_len, input logic with_pcr);
        logic [31:0] rnd;
        rnd = $urandom();
        for (int i = 0; i < tspp_pkg::PacketBytes; i++) p[i] = 8'($urandom_range(0, 255));
        p[0] = tspp_pkg::SyncValue;
        p[1] = {rnd[0], rnd[1], 1'b0, pid[12:8]};
        p[2] = pid[7:0];
        p[3] = {rnd[3:2], afc, rnd[7:4]};
        if (afc[1]) begin
            p[4] = 8'(af_len);
            if (af_len > 0) p[5] = {rnd[10:8], with_pcr, rnd[14:11]};
        end
    endfunction

    function automatic void build_pat(output logic [7:0] p [tspp_pkg::PacketBytes],
                                      input int unsigned sec_len, input logic zero_prog);
        build_packet(p, 13'd0, 2'b01, 0, 1'b0);
        p[6] = {4'hB, sec_len[11:8]};
        p[7] = sec_len[7:0];
        for (int e = 0; e < 40; e++) begin
            if (13 + 4 * e + 3 < tspp_pkg::PacketBytes) begin
                p[13 + 4 * e]     = (zero_prog && e == 1) ? 8'd0
                                                          : 8'($urandom_range(0, 255));
                p[13 + 4 * e + 1] = (zero_prog && e == 1) ? 8'd0
                                                          : 8'($urandom_range(1, 255));
                // keep PMT PIDs within a small range so some packets hit them
                p[13 + 4 * e + 2] = {($urandom_range(0, 7) == 0) ? 3'b111 : 3'b000, 5'd0};
                p[13 + 4 * e + 3] = 8'($urandom_range(16, 40));
            end
        end
    endfunction

    task automatic write_pcr_enable(logic value);
        wait (expected_results.size() == 0);
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        pcr_enable = value;
    endtask

    // noise while hunting, then a packet with all header bits set and PCR disabled
    task automatic test_hunt_and_header();
        logic [7:0] p [tspp_pkg::PacketBytes];
        send_byte(8'h00);
        send_byte(8'hFF);
        build_packet(p, 13'h1FFF, 2'b11, 7, 1'b1);
        p[1] = 8'hFF; p[3] = 8'hFF;
        for (int i = 6; i < 12; i++) p[i] = 8'hFF;
        send_packet(p);
        stop_input();
    endtask

    // PCR reported inside an adaptation field that runs past the packet end
    task automatic test_pcr_paths();
        logic [7:0] p [tspp_pkg::PacketBytes];
        build_packet(p, 13'h0101, 2'b11, 250, 1'b1);
        send_packet(p);
        stop_input();
    endtask

    // PAT with zero program and oversized section, then a PMT packet with a short PCR
    task automatic test_pat_tables();
        logic [7:0] p [tspp_pkg::PacketBytes];
        build_pat(p, 4095, 1'b1);
        send_packet(p);
        build_packet(p, pmt_pid_q[0], 2'b11, 3, 1'b1);
        send_packet(p);
        stop_input();
    endtask

    // hold the receiver off while bytes keep coming, so the input stalls
    task automatic test_output_backpressure();
        logic [7:0] p [tspp_pkg::PacketBytes];
        build_packet(p, 13'h0777, 2'b01, 0, 1'b0);
        fork
            begin
                hold_off_rx = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off_rx = 1'b0;
            end
            begin
                send_packet(p, 1'b0);
                stop_input();
            end
        join
        @(negedge i_clk);
    endtask

    // bad sync byte, hunt, resync, then a packet with reserved field control
    task automatic test_sync_error();
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(tspp_pkg::SyncValue);
        send_byte(8'h00);
        send_byte(8'h10);
        send_byte(8'h0F);
        for (int i = 0; i < 4; i++) send_byte(8'hAA);
        stop_input();
    endtask

    // compare accepted results against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tspp_pkg::t_result got;
            tspp_pkg::t_result exp_r;
            got = '{o_kind, o_pid, o_unit_start, o_transport_error, o_scrambling,
                    o_field_control, o_continuity, o_clock_base, o_clock_extension,
                    o_payload_byte, o_packet_index};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int unsigned gap;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_rx) begin
                i_ready <= 1'b0;
            end else begin
                gap = random_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = 1'b0;
        i_valid = 1'b0; i_stream_byte = 8'h00;
        pcr_enable = 1'b0; pos_q = 0; hdr_q = '0; af_len_q = '0; af_flags_q = '0;
        pcr_shift_q = '0; sec_left_q = 0; entry_q = '0; entry_idx_q = 0;
        pmt_valid_q = '0; pkt_count_q = '0;
        for (int i = 0; i < tspp_pkg::PmtEntries; i++) pmt_pid_q[i] = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_hunt_and_header();
        write_pcr_enable(1'b1);
        test_pcr_paths();
        test_pat_tables();
        test_output_backpressure();
        test_sync_error();

        wait (expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/tspp_pkg.sv
src/tspp_pmt_match.sv
src/ts_packet_parser_top.sv
test/tb_ts_packet_parser_top.sv
